// ===== hw/rtl/rbp_pkg.sv =====
package rbp_pkg;

   localparam int GROUP_PIXELS = 8;
   localparam int PLANE_COUNT  = 5;
   localparam int CODE_W       = 5;
   localparam int CHAN_W       = 8;
   localparam int SLOT_W       = 3;
   localparam int PLANE_W      = 3;

   localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(GROUP_PIXELS - 1);
   localparam logic [PLANE_W-1:0] LAST_PLANE = PLANE_W'(PLANE_COUNT - 1);

   // Decision points of (v*3+127)/255 and (v+127)/255
   localparam logic [CHAN_W-1:0] RG_STEP1 = 8'd43;
   localparam logic [CHAN_W-1:0] RG_STEP2 = 8'd128;
   localparam logic [CHAN_W-1:0] RG_STEP3 = 8'd213;
   localparam logic [CHAN_W-1:0] B_STEP1  = 8'd128;

   typedef logic [CODE_W-1:0] code_type;
   typedef logic [GROUP_PIXELS-1:0][CODE_W-1:0] group_type;

   function automatic logic [1:0] quant_rg(input logic [CHAN_W-1:0] v);
      logic [1:0] q;
      if (v >= RG_STEP3) begin
         q = 2'd3;
      end else if (v >= RG_STEP2) begin
         q = 2'd2;
      end else if (v >= RG_STEP1) begin
         q = 2'd1;
      end else begin
         q = 2'd0;
      end
      return q;
   endfunction

   function automatic code_type quantize(input logic [CHAN_W-1:0] r,
                                         input logic [CHAN_W-1:0] g,
                                         input logic [CHAN_W-1:0] b);
      return {quant_rg(r), quant_rg(g), b >= B_STEP1};
   endfunction

endpackage

// ===== hw/rtl/rgb221_bitplane_packer_top.sv =====
// RGB 2-2-1 quantizer and bitplane packer. Each req beat carries one pixel;
// the front end rounds it to a 5-bit code (red and green to 2 bits, blue to
// 1 bit, R in bits 4..3, G in 2..1, B in 0; a pad beat codes as zero) and
// collects eight codes. The beat that closes a group of eight pushes the
// group into a two-entry queue, and the back end then sends five rsp beats,
// plane 0 first: plane k holds bit k of pixel i at bit i, and the fifth beat
// carries tlast. The input side takes one pixel per cycle; it stalls only on
// the closing pixel of a group while both queue entries are occupied. The
// output side sends one plane beat per cycle while rsp_tready is high, so a
// steady stream of one pixel per cycle with rsp_tready held high never backs
// up. A closed group passes a queue entry, then the back end's group register.
module rgb221_bitplane_packer_top
   import rbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   input  logic        req_tuser,   // pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // plane_byte [7:0], plane_index [10:8], zero
   output logic        rsp_tlast
);

   logic               grp_push_valid, grp_push_ready;
   logic               grp_pop_valid, grp_pop_ready;
   group_type          grp_push_data, grp_pop_data;
   logic [7:0]         plane_byte;
   logic [PLANE_W-1:0] plane_index;

   // quantize and gather eight pixels
   rbp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .pad       (req_tuser),
      .grp_valid (grp_push_valid),
      .grp_ready (grp_push_ready),
      .grp_data  (grp_push_data)
   );

   // hold finished groups so either side can stall on its own
   rbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (grp_push_valid),
      .push_ready (grp_push_ready),
      .push_data  (grp_push_data),
      .pop_valid  (grp_pop_valid),
      .pop_ready  (grp_pop_ready),
      .pop_data   (grp_pop_data)
   );

   // send five plane beats per group
   rbp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .grp_valid   (grp_pop_valid),
      .grp_ready   (grp_pop_ready),
      .grp_data    (grp_pop_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .plane_byte  (plane_byte),
      .plane_index (plane_index),
      .last        (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, plane_index, plane_byte};

endmodule

// ===== hw/rtl/rbp_front.sv =====
module rbp_front
   import rbp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [CHAN_W-1:0] red,
   input  logic [CHAN_W-1:0] green,
   input  logic [CHAN_W-1:0] blue,
   input  logic              pad,
   output logic              grp_valid,
   input  logic              grp_ready,
   output group_type         grp_data
);

   logic [SLOT_W-1:0] slot_ff, slot_in;
   code_type          codes_ff [GROUP_PIXELS-1];
   code_type          code;
   logic              accept;

   assign code     = pad ? '0 : quantize(red, green, blue);
   // stall only on the closing pixel of a group when the queue is full
   assign in_ready = (slot_ff != LAST_SLOT) || grp_ready;
   assign accept   = in_valid && in_ready;
   assign slot_in  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;

   assign grp_valid = in_valid && (slot_ff == LAST_SLOT);
   always_comb begin
      for (int i = 0; i < GROUP_PIXELS - 1; i++) begin
         grp_data[i] = codes_ff[i];
      end
      grp_data[GROUP_PIXELS-1] = code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (accept) begin
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < GROUP_PIXELS - 1; i++) begin
         if (accept && slot_ff == SLOT_W'(i)) begin
            codes_ff[i] <= code;
         end
      end
   end

endmodule

// ===== hw/rtl/rbp_queue.sv =====
module rbp_queue
   import rbp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  group_type push_data,
   output logic      pop_valid,
   input  logic      pop_ready,
   output group_type pop_data
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   group_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/rbp_back.sv =====
module rbp_back
   import rbp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               grp_valid,
   output logic               grp_ready,
   input  group_type          grp_data,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         plane_byte,
   output logic [PLANE_W-1:0] plane_index,
   output logic               last
);

   logic               busy_ff, busy_in;
   logic [PLANE_W-1:0] plane_ff, plane_in;
   group_type          group_ff;
   logic               done;

   assign done      = busy_ff && out_ready && (plane_ff == LAST_PLANE);
   assign grp_ready = !busy_ff || done;

   always_comb begin
      busy_in  = busy_ff;
      plane_in = plane_ff;
      if (grp_ready) begin
         busy_in  = grp_valid;
         plane_in = '0;
      end else if (out_ready) begin
         plane_in = plane_ff + 1'b1;
      end
   end

   // pick code bit plane_ff of every pixel
   always_comb begin
      for (int i = 0; i < GROUP_PIXELS; i++) begin
         plane_byte[i] = group_ff[i][plane_ff];
      end
   end

   assign out_valid   = busy_ff;
   assign plane_index = plane_ff;
   assign last        = (plane_ff == LAST_PLANE);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         plane_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         plane_ff <= plane_in;
      end
   end

   always_ff @(posedge clock) begin
      if (grp_ready && grp_valid) begin
         group_ff <= grp_data;
      end
   end

endmodule
